[design/tgt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_pkg: shared types and constants for the twiddle gain tuner
// Fixed-point limits, register addresses and controller/datapath interface.
// ----------------------------------------------------------------------------
package tgt_pkg;

    localparam int COUNT_BITS = 11;
    localparam int SUM_W      = 41;
    localparam int MEAN_W     = 40;
    localparam int DIV_W      = SUM_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [MEAN_W-1:0] MEAN_MAX  = '1;
    localparam logic [MEAN_W-1:0] BEST_RESET = 40'd6553600000;
    localparam logic [31:0] STEP_ONE       = 32'd16777216;
    localparam logic [31:0] STEP_HUNDREDTH = 32'd167772;
    localparam logic [31:0] STEP_MAX       = 32'h7FFF_FFFF;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd14667;
    localparam logic [15:0] SPEED_LIMIT = 16'd256;

    // gains loaded at reset, Q8.24
    localparam logic [31:0] INIT_KP = 32'd8891924;
    localparam logic [31:0] INIT_KI = 32'd83886;
    localparam logic [31:0] INIT_KD = 32'd62075699;

    // ceil(2^35 / 10): x / 10 as (x * RECIP10) >> 35, exact for x < 2^32
    localparam logic [31:0] RECIP10 = 32'd3435973837;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_MIN    = 3'd1;
    localparam logic [2:0] ADDR_MAX    = 3'd2;
    localparam logic [2:0] ADDR_TOL    = 3'd3;
    localparam logic [2:0] ADDR_KP     = 3'd4;
    localparam logic [2:0] ADDR_KI     = 3'd5;
    localparam logic [2:0] ADDR_KD     = 3'd6;

    typedef struct packed {
        logic      load;      // count sample, update accumulators
        logic      div_start; // start divider
        logic      train;     // run trial-end update
        logic      clear;     // clear accumulators after training
        logic      advance;   // move index and add step
    } dp_cmd_t;

    typedef struct packed {
        logic      div_busy;
        logic      active;
        logic      can_train;
        logic      do_stop;
        logic      settled_after;
    } dp_status_t;

    function automatic logic [31:0] sat_add(input logic [31:0] g, input logic [33:0] d);
        logic signed [34:0] s;
        s = $signed({{3{g[31]}}, g}) + $signed({d[33], d});
        if (s > 35'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -35'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

endpackage

[design/tgt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_div: restoring divider, one quotient bit per cycle
// Divides the 41-bit error sum by the sample count.
// ----------------------------------------------------------------------------
module tgt_div
    import tgt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  busy,
    output logic [DIV_W-1:0]      quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]    q_reg, q_next;
    logic [COUNT_BITS:0] r_reg, r_next;
    logic [COUNT_BITS-1:0] d_reg, d_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [COUNT_BITS:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[COUNT_BITS-1:0], q_reg[DIV_W-1]};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CW'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    // a zero count would give all ones, so the quotient is forced to zero
    assign quotient = (d_reg == '0) ? '0 : q_reg;
endmodule

[design/tgt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_datapath: accumulators, gain/step store and twiddle update
// Acts on controller commands; reports trial-end conditions.
// ----------------------------------------------------------------------------
module tgt_datapath
    import tgt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [15:0]           cte,
    input  logic [15:0]           speed,
    input  logic [15:0]           angle,
    input  logic [9:0]            min_samples,
    input  logic [9:0]            max_samples,
    input  logic [24:0]           step_tolerance,
    input  logic                  gain_wr,
    input  logic [1:0]            gain_wr_idx,
    input  logic [31:0]           gain_wr_data,
    output logic [31:0]           gain_p,
    output logic [31:0]           gain_i,
    output logic [31:0]           gain_d,
    output logic [30:0]           mean_out
);
    logic [31:0] gain_reg [3];
    logic [31:0] gain_next [3];
    logic [31:0] step_reg [3];
    logic [31:0] step_next [3];
    logic [2:0]  settled_reg, settled_next;
    logic [1:0]  idx_reg, idx_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [MEAN_W-1:0] best_reg, best_next;
    logic first_reg, first_next;
    logic active_reg, active_next;

    logic [31:0] sq;
    logic [SUM_W:0] sum_add;
    logic [33:0] tsum;
    logic limit;
    logic [DIV_W-1:0] quo;
    logic [MEAN_W-1:0] mean;
    logic div_busy;
    logic [1:0] ci, ni;
    logic        better;
    logic [31:0] dv_x;
    logic [63:0] dv_p;
    logic [31:0] dv_q;
    logic [32:0] grow_s;
    logic [31:0] grow_q, shrink_q;

    tgt_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(sum_reg), .divisor(count_reg), .busy(div_busy), .quotient(quo)
    );

    assign sq = 32'($signed(cte) * $signed(cte));
    assign sum_add = {1'b0, sum_reg} + {{(SUM_W-31){1'b0}}, sq[30:0]};
    assign limit = (speed < SPEED_LIMIT) || ($signed(angle) > ANGLE_LIMIT)
                   || ($signed(angle) < -ANGLE_LIMIT);
    assign tsum = {2'b0, step_reg[0]} + {2'b0, step_reg[1]} + {2'b0, step_reg[2]};
    assign mean = (quo > {1'b0, MEAN_MAX}) ? MEAN_MAX : quo[MEAN_W-1:0];
    assign ci = (idx_reg > 2'd2) ? 2'd0 : idx_reg;
    assign ni = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
    assign better = mean < best_reg;

    // x*1.1 and x*0.9 rounded half up: s + (s+5)/10 and s - (s+4)/10;
    // one shared divide by 10 through the reciprocal
    assign dv_x = step_reg[ci] + (better ? 32'd5 : 32'd4);
    assign dv_p = {32'b0, dv_x} * {32'b0, RECIP10};
    assign dv_q = {3'b0, dv_p[63:35]};
    assign grow_s = {1'b0, step_reg[ci]} + {1'b0, dv_q};
    assign grow_q = (grow_s > {1'b0, STEP_MAX}) ? STEP_MAX : grow_s[31:0];
    assign shrink_q = step_reg[ci] - dv_q;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gain_next[k] = gain_reg[k];
            step_next[k] = step_reg[k];
        end
        settled_next = settled_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        sum_next = sum_reg;
        best_next = best_reg;
        first_next = first_reg;
        active_next = active_reg;
        if (gain_wr) gain_next[gain_wr_idx] = gain_wr_data;
        if (cmd.load) begin
            active_next = (count_reg > {1'b0, min_samples} && limit)
                          || count_reg > {1'b0, max_samples};
            if (count_reg < COUNT_MAX) count_next = count_reg + 1'b1;
            sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
        end
        if (cmd.train) begin
            if (first_reg) begin
                first_next = 1'b0;
            end else if (better) begin
                best_next = mean;
                step_next[ci] = grow_q;
                settled_next[ci] = 1'b1;
            end else if (settled_reg[ci]) begin
                gain_next[ci] = sat_add(gain_reg[ci], -{1'b0, step_reg[ci], 1'b0});
                settled_next[ci] = 1'b0;
            end else begin
                gain_next[ci] = sat_add(gain_reg[ci], {2'b0, step_reg[ci]});
                step_next[ci] = shrink_q;
                settled_next[ci] = 1'b1;
            end
            idx_next = ci;
        end
        if (cmd.advance) begin
            gain_next[ni] = sat_add(gain_reg[ni], {2'b0, step_reg[ni]});
            idx_next = ni;
        end
        if (cmd.clear) begin
            count_next = '0;
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[0] <= INIT_KP;
            gain_reg[1] <= INIT_KI;
            gain_reg[2] <= INIT_KD;
            step_reg[0] <= STEP_ONE;
            step_reg[1] <= STEP_HUNDREDTH;
            step_reg[2] <= STEP_ONE;
            settled_reg <= 3'b111;
            idx_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            best_reg <= BEST_RESET;
            first_reg <= 1'b1;
            active_reg <= 1'b0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                gain_reg[k] <= gain_next[k];
                step_reg[k] <= step_next[k];
            end
            settled_reg <= settled_next;
            idx_reg <= idx_next;
            count_reg <= count_next;
            sum_reg <= sum_next;
            best_reg <= best_next;
            first_reg <= first_next;
            active_reg <= active_next;
        end
    end

    assign status.div_busy = div_busy;
    assign status.active = active_reg;
    assign status.can_train = tsum > {9'b0, step_tolerance};
    assign status.do_stop = tsum < {9'b0, step_tolerance};
    assign status.settled_after = settled_reg[ci];

    assign gain_p = gain_reg[0];
    assign gain_i = gain_reg[1];
    assign gain_d = gain_reg[2];
    assign mean_out = (count_reg == '0) ? 31'd0 :
                      (quo > 41'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[30:0];
endmodule

[design/tgt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgt_ctrl: sequencer for one telemetry beat
// Tuning: load, divide, trial-end train/advance; final divide, present result.
// ----------------------------------------------------------------------------
module tgt_ctrl
    import tgt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       tune_enable,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       idle,
    output logic       res_valid,
    output logic       restart,
    output logic       stopped,
    input  logic       res_take
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_WAIT1, S_DECIDE, S_ADV, S_DIV2, S_WAIT2, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic restart_reg, restart_next;
    logic stopped_reg, stopped_next;

    always_comb begin
        state_next = state_reg;
        restart_next = restart_reg;
        stopped_next = stopped_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    restart_next = 1'b0;
                    cmd.load = tune_enable && !stopped_reg;
                    state_next = (tune_enable && !stopped_reg) ? S_DIV1 : S_DIV2;
                end
            end
            S_DIV1: begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT1;
            end
            S_WAIT1: if (!status.div_busy) state_next = S_DECIDE;
            S_DECIDE: begin
                if (status.active && status.can_train) begin
                    cmd.train = 1'b1;
                    restart_next = 1'b1;
                    state_next = S_ADV;
                end else begin
                    if (status.do_stop) stopped_next = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_ADV: begin
                cmd.advance = status.settled_after;
                cmd.clear = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2: begin
                cmd.div_start = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2: if (!status.div_busy) state_next = S_OUT;
            S_OUT: if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            restart_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            restart_reg <= restart_next;
            stopped_reg <= stopped_next;
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign restart = restart_reg;
    assign stopped = stopped_reg;
endmodule

[design/twiddle_gain_tuner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twiddle_gain_tuner: twiddle coordinate-descent tuner for three PID gains
// While tuning, each beat adds the squared cross-track error to the trial sum;
// a trial end runs one twiddle step and raises restart_request.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one sample in flight at a time. m_tvalid rises
// once the final divide of the accepted beat is done; s_tready comes back
// the cycle after the result beat is taken. The bit-serial 41-bit divider
// (error sum / sample count, run twice per beat while tuning and once when
// the tuner is off or stopped) sets the rate; a stalled receiver stalls the
// input. Gains and step sizes are signed/unsigned Q8.24, inputs Q8.8, the
// mean error unsigned Q15.16. Writes to initial_kp/ki/kd also load the live
// gain. Registers at 4*index.
module twiddle_gain_tuner
    import tgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] cross_track_error, [31:16] vehicle_speed, [47:32] steer_angle_deg
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] gain_p, [63:32] gain_i, [95:64] gain_d, [126:96] trial_mean_error,
    // [127] restart_request
    output logic [127:0] m_tdata,
    // [0] tuning_done
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic        enable_reg;
    logic [9:0]  min_reg, max_reg;
    logic [24:0] tol_reg;
    logic [31:0] init_reg [3];
    logic        wr;
    logic [2:0]  ra;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        idle, res_valid, restart, stopped;
    logic [31:0] gp, gi, gd;
    logic [30:0] mean;
    logic        gw;
    logic [1:0]  gw_idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign ra = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            min_reg <= 10'd50;
            max_reg <= 10'd600;
            tol_reg <= 25'd168;
            init_reg[0] <= INIT_KP;
            init_reg[1] <= INIT_KI;
            init_reg[2] <= INIT_KD;
        end else if (wr) begin
            unique case (ra)
                ADDR_ENABLE: enable_reg <= pwdata[0];
                ADDR_MIN:    min_reg <= pwdata[9:0];
                ADDR_MAX:    max_reg <= pwdata[9:0];
                ADDR_TOL:    tol_reg <= pwdata[24:0];
                ADDR_KP:     init_reg[0] <= pwdata;
                ADDR_KI:     init_reg[1] <= pwdata;
                ADDR_KD:     init_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ra)
            ADDR_ENABLE: prdata = {31'b0, enable_reg};
            ADDR_MIN:    prdata = {22'b0, min_reg};
            ADDR_MAX:    prdata = {22'b0, max_reg};
            ADDR_TOL:    prdata = {7'b0, tol_reg};
            ADDR_KP:     prdata = init_reg[0];
            ADDR_KI:     prdata = init_reg[1];
            ADDR_KD:     prdata = init_reg[2];
            default:     prdata = '0;
        endcase
    end

    // initial gain writes also load the live gain
    assign gw = wr && (ra == ADDR_KP || ra == ADDR_KI || ra == ADDR_KD);
    assign gw_idx = 2'(ra - ADDR_KP);

    tgt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .tune_enable(enable_reg),
        .status(status), .cmd(cmd), .idle(idle), .res_valid(res_valid),
        .restart(restart), .stopped(stopped), .res_take(m_tready)
    );

    tgt_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .cte(s_tdata[15:0]), .speed(s_tdata[31:16]), .angle(s_tdata[47:32]),
        .min_samples(min_reg), .max_samples(max_reg), .step_tolerance(tol_reg),
        .gain_wr(gw), .gain_wr_idx(gw_idx), .gain_wr_data(pwdata),
        .gain_p(gp), .gain_i(gi), .gain_d(gd), .mean_out(mean)
    );

    assign s_tready = idle;
    assign m_tvalid = res_valid;
    assign m_tdata = {restart, mean, gd, gi, gp};
    assign m_tuser = stopped;
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for twiddle_gain_tuner
// Streams telemetry beats through the tuner, predicts every gain update in a
// local twiddle model, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module testbench;
    import tgt_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        logic signed [15:0] angle;
        logic [15:0]        speed;
        logic signed [15:0] cte;
    } sample_t;

    typedef struct {
        logic [31:0] gp, gi, gd;
        logic [30:0] mean;
        logic        restart;
        logic        done;
    } gains_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    twiddle_gain_tuner dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tuner shadow state
    logic        en_r;
    logic [9:0]  min_r, max_r;
    logic [24:0] tol_r;
    logic signed [31:0] gain_m [3];
    logic [31:0] step_m [3];
    logic        settled_m [3];
    logic [1:0]  idx_m;
    logic [COUNT_BITS-1:0] count_m;
    logic [SUM_W-1:0] esum_m;
    logic [MEAN_W-1:0] best_m;
    logic        first_m, stop_m;

    sample_t sample_q [$];
    gains_t  gains_q [$];
    int      send_idle_pct = 0, recv_stall_pct = 0;
    bit      hold_tog = 1'b0, hold_seen = 1'b0;
    int      hold_left = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    function automatic void bump_gain(int k, longint d);
        longint s;
        s = longint'(gain_m[k]) + d;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        gain_m[k] = s[31:0];
    endfunction

    function automatic void twiddle(logic [63:0] mean);
        int i;
        logic [63:0] v;
        i = (idx_m > 2) ? 0 : idx_m;
        if (first_m) begin
            first_m = 1'b0;
        end else if (mean < best_m) begin
            best_m = mean[MEAN_W-1:0];
            v = (64'(step_m[i]) * 11 + 5) / 10;
            step_m[i] = (v > 64'(STEP_MAX)) ? STEP_MAX : v[31:0];
            settled_m[i] = 1'b1;
        end else if (settled_m[i]) begin
            bump_gain(i, -2 * longint'(step_m[i]));
            settled_m[i] = 1'b0;
        end else begin
            bump_gain(i, longint'(step_m[i]));
            v = (64'(step_m[i]) * 9 + 5) / 10;
            step_m[i] = v[31:0];
            settled_m[i] = 1'b1;
        end
        if (settled_m[i]) begin
            i = (i == 2) ? 0 : i + 1;
            bump_gain(i, longint'(step_m[i]));
        end
        idx_m = i[1:0];
    endfunction

    function automatic gains_t predict_gains(sample_t s);
        gains_t r;
        logic lim, act;
        logic [63:0] sq, tsum, sum, mean;
        r.restart = 1'b0;
        if (en_r && !stop_m) begin
            lim = s.speed < SPEED_LIMIT || s.angle > ANGLE_LIMIT || s.angle < -ANGLE_LIMIT;
            act = (count_m > min_r && lim) || count_m > max_r;
            sq = 64'(longint'(s.cte) * longint'(s.cte));
            tsum = 64'(step_m[0]) + step_m[1] + step_m[2];
            if (count_m != COUNT_MAX) count_m++;
            sum = 64'(esum_m) + sq;
            esum_m = (sum > 64'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
            mean = 64'(esum_m) / count_m;
            if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
            if (act && tsum > 64'(tol_r)) begin
                twiddle(mean);
                count_m = '0;
                esum_m = '0;
                r.restart = 1'b1;
            end else if (tsum < 64'(tol_r)) begin
                stop_m = 1'b1;
            end
        end
        mean = (count_m == 0) ? 64'd0 : 64'(esum_m) / count_m;
        if (mean > 64'h7FFF_FFFF) mean = 64'h7FFF_FFFF;
        r.mean = mean[30:0];
        r.gp = gain_m[0];
        r.gi = gain_m[1];
        r.gd = gain_m[2];
        r.done = stop_m;
        return r;
    endfunction

    // sender: one beat per handshake, random idle cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q[0];
                    gains_q.push_back(predict_gains(sample_q.pop_front()));
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls; a toggle of hold_tog starts a long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_tog != hold_seen) begin
                hold_seen <= hold_tog;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        gains_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (gains_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing expected");
            end else begin
                e = gains_q.pop_front();
                if (m_tdata[31:0] !== e.gp || m_tdata[63:32] !== e.gi ||
                    m_tdata[95:64] !== e.gd || m_tdata[126:96] !== e.mean ||
                    m_tdata[127] !== e.restart || m_tuser !== e.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp p=%h i=%h d=%h m=%h r=%b t=%b got %h t=%b",
                                 e.gp, e.gi, e.gd, e.mean, e.restart, e.done,
                                 m_tdata, m_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ADDR_ENABLE: en_r = val[0];
            ADDR_MIN:    min_r = val[9:0];
            ADDR_MAX:    max_r = val[9:0];
            ADDR_TOL:    tol_r = val[24:0];
            default:     gain_m[idx - ADDR_KP] = val;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_q.size() > 0 || gains_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly driving-like samples with random error; some run-enders
    task automatic queue_random(int n);
        sample_t s;
        repeat (n) begin
            s.cte = $urandom_range(9) == 0 ? 16'($urandom) : 16'($signed($urandom_range(2048)) - 1024);
            s.speed = $urandom_range(19) == 0 ? 16'($urandom_range(255)) : 16'($urandom);
            s.angle = $urandom_range(19) == 0 ? 16'($urandom)
                                              : 16'($signed($urandom_range(28000)) - 14000);
            sample_q.push_back(s);
        end
    endtask

    task automatic queue_sample(int c, int sp, int an);
        sample_t s;
        s.cte = 16'(c); s.speed = 16'(sp); s.angle = 16'(an);
        sample_q.push_back(s);
    endtask

    initial begin
        en_r = 0; min_r = 50; max_r = 600; tol_r = 168;
        gain_m[0] = 8891924; gain_m[1] = 83886; gain_m[2] = 62075699;
        step_m[0] = STEP_ONE; step_m[1] = STEP_HUNDREDTH; step_m[2] = STEP_ONE;
        settled_m[0] = 1; settled_m[1] = 1; settled_m[2] = 1;
        idx_m = 0; count_m = 0; esum_m = 0; best_m = BEST_RESET;
        first_m = 1; stop_m = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // tuner off: state frozen
        queue_sample(16'h7FFF, 0, 0);
        wait_drained();
        write_reg(ADDR_ENABLE, 1);
        write_reg(ADDR_MIN, 0);
        write_reg(ADDR_MAX, 3);
        // extremes, limit edges and trial ends
        queue_sample(-32768, 0, 0);
        queue_sample(32767, 65535, 32767);
        queue_sample(0, 255, 14667);
        queue_sample(5, 256, 14668);
        queue_sample(-5, 256, -14667);
        queue_sample(100, 256, -14668);
        queue_sample(-32768, 65535, -32768);
        for (int k = 0; k < 12; k++) queue_sample(k * 300 - 1000, 40000, 0);
        wait_drained();

        // saturated gains
        write_reg(ADDR_KP, 32'h7FFF_FFFF);
        write_reg(ADDR_KI, 32'h8000_0000);
        write_reg(ADDR_KD, 32'h0);
        write_reg(ADDR_MIN, 1023);
        write_reg(ADDR_MAX, 1023);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 19) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 19) : 0;
            write_reg(ADDR_MIN, ph == 0 ? 1023 : $urandom_range(12));
            write_reg(ADDR_MAX, ph == 0 ? 1023 : $urandom_range(40));
            write_reg(ADDR_KP, $urandom);
            if (ph == 0) begin
                queue_random(30);
                queue_random(1);
                hold_tog = ~hold_tog;
                repeat (2) @(posedge aclk);
                wait (hold_left == 0);
                // long run up to the maximum trial length
                repeat (1000) queue_sample(32767, 65535, 0);
            end else begin
                queue_random(30);
            end
            wait_drained();
        end
        // tolerance extremes: huge stops tuning, sum equal never trains
        write_reg(ADDR_TOL, step_m[0] + step_m[1] + step_m[2]);
        queue_random(20);
        wait_drained();
        write_reg(ADDR_TOL, 25'h1000000);
        write_reg(ADDR_MIN, 2);
        write_reg(ADDR_MAX, 5);
        queue_random(20);
        wait_drained();
        write_reg(ADDR_TOL, 0);
        write_reg(ADDR_ENABLE, 0);
        queue_random(5);
        wait_drained();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[sim.f]
design/tgt_pkg.sv
design/tgt_div.sv
design/tgt_datapath.sv
design/tgt_ctrl.sv
design/twiddle_gain_tuner.sv
tb/testbench.sv
